FILE: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the barometric compensation block
// Calibration word layouts, the queue beat between front and back, and the
// fixed constants of the compensation formulas.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Default number of entries in the front-to-back queue.
  localparam int BSC_QUEUE_DEPTH = 4;

  // Number of quotient bits the divider produces, one per stage.
  localparam int DIV_STEPS = 64;

  // Constants of the compensation formulas.
  localparam int T_OFFSET = 128000;
  localparam int P_BASE   = 1048576;
  localparam int P_SCALE  = 3125;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_TEMP = 2'd0,
    REG_PA   = 2'd1,
    REG_PB   = 2'd2,
    REG_P9   = 2'd3
  } reg_idx_t;

  // Temperature calibration words.
  typedef struct packed {
    logic signed [15:0] t3;
    logic signed [15:0] t2;
    logic        [15:0] t1;
  } tcoef_t;

  // Pressure calibration words.
  typedef struct packed {
    logic signed [15:0] p9;
    logic signed [15:0] p8;
    logic signed [15:0] p7;
    logic signed [15:0] p6;
    logic signed [15:0] p5;
    logic signed [15:0] p4;
    logic signed [15:0] p3;
    logic signed [15:0] p2;
    logic        [15:0] p1;
  } pcoef_t;

  // One beat of the queue: finished temperature terms and the division task.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        zero;
    logic        neg;
    logic [63:0] mn;
    logic [63:0] md;
  } qitem_t;

endpackage

FILE: hw/rtl/bsc_fifo.sv
// ----------------------------------------------------------------------------
// bsc_fifo: small register queue between front and back
// Fall-through read of the oldest entry; push is refused by the writer
// while full.
// ----------------------------------------------------------------------------
module bsc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/bsc_front.sv
// ----------------------------------------------------------------------------
// bsc_front: burst intake, temperature path and divider operand setup
// A thirteen-stage pipeline that unpacks the burst, computes temperature and
// fine temperature, builds the pressure dividend and divisor, and flags a
// zero divisor before handing one beat to the queue.
// ----------------------------------------------------------------------------
module bsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                burst_valid,
  input  logic [47:0]         raw_burst,
  input  bsc_pkg::tcoef_t     tcoef,
  input  bsc_pkg::pcoef_t     pcoef,
  output logic                push,
  output bsc_pkg::qitem_t     push_data
);

  import bsc_pkg::*;

  localparam int NST = 13;

  typedef struct packed {
    logic [19:0] adc_p;
    logic [19:0] adc_t;
    logic [31:0] x;
    logic [31:0] d;
    logic [31:0] m1;
    logic [31:0] dd;
    logic [31:0] a;
    logic [31:0] m2;
    logic [31:0] fine;
    logic [31:0] temp;
    logic [33:0] v1;
    logic [31:0] mag;
    logic [63:0] sq;
    logic [63:0] v1p5;
    logic [63:0] v1p2;
    logic [47:0] ll6;
    logic [47:0] hl6;
    logic [47:0] ll3;
    logic [47:0] hl3;
    logic [63:0] sqp3;
    logic [63:0] v2;
    logic [63:0] v1d;
    logic [63:0] n0;
    logic [47:0] plo;
    logic [47:0] phi;
    logic [43:0] nlo;
    logic [43:0] nhi;
    logic [63:0] v1e;
    logic [63:0] num;
  } fs_t;

  fs_t        s [NST];
  fs_t        n [NST];
  logic [NST-1:0] v;

  logic [63:0] sqp6;
  logic [20:0] pb;

  // Stage logic, one block per pipeline step.
  always_comb begin
    n[0]       = s[0];
    n[0].adc_p = raw_burst[47:28];
    n[0].adc_t = raw_burst[23:4];

    // Offsets of the raw temperature.
    n[1]   = s[0];
    n[1].x = 32'(s[0].adc_t >> 3) - {15'b0, tcoef.t1, 1'b0};
    n[1].d = 32'(s[0].adc_t >> 4) - {16'b0, tcoef.t1};

    // First products of the temperature path.
    n[2]    = s[1];
    n[2].m1 = s[1].x * {{16{tcoef.t2[15]}}, tcoef.t2};
    n[2].dd = s[1].d * s[1].d;

    // Scale and apply the quadratic coefficient.
    n[3]    = s[2];
    n[3].a  = 32'($signed(s[2].m1) >>> 11);
    n[3].m2 = 32'($signed(s[2].dd) >>> 12) * {{16{tcoef.t3[15]}}, tcoef.t3};

    // Fine temperature.
    n[4]      = s[3];
    n[4].fine = s[3].a + 32'($signed(s[3].m2) >>> 14);

    // Temperature in centidegrees and the centered fine term.
    n[5]      = s[4];
    n[5].temp = 32'($signed({s[4].fine[29:0], 2'b0} + s[4].fine + 32'd128) >>> 8);
    n[5].v1   = {{2{s[4].fine[31]}}, s[4].fine} - 34'(T_OFFSET);
    n[5].mag  = n[5].v1[33] ? 32'(-n[5].v1) : n[5].v1[31:0];

    // Square of the centered term and the linear products.
    n[6]      = s[5];
    n[6].sq   = {32'b0, s[5].mag} * {32'b0, s[5].mag};
    n[6].v1p5 = $signed(s[5].v1) * pcoef.p5;
    n[6].v1p2 = $signed(s[5].v1) * pcoef.p2;

    // Partial products of the square with the quadratic coefficients.
    n[7]     = s[6];
    n[7].ll6 = s[6].sq[31:0] * pcoef.p6;
    n[7].hl6 = s[6].sq[63:32] * pcoef.p6;
    n[7].ll3 = s[6].sq[31:0] * pcoef.p3;
    n[7].hl3 = s[6].sq[63:32] * pcoef.p3;

    // Combine partials; the second variable of the pressure path.
    sqp6      = 64'(s[7].ll6) + {s[7].hl6[31:0], 32'b0}
              - (pcoef.p6[15] ? {s[7].sq[47:0], 16'b0} : 64'b0);
    n[8]      = s[7];
    n[8].sqp3 = 64'(s[7].ll3) + {s[7].hl3[31:0], 32'b0}
              - (pcoef.p3[15] ? {s[7].sq[47:0], 16'b0} : 64'b0);
    n[8].v2   = sqp6 + {s[7].v1p5[46:0], 17'b0}
              + ({{48{pcoef.p4[15]}}, pcoef.p4} << 35);

    // Divisor before scaling, and the dividend before the constant factor.
    pb        = 21'(P_BASE) - {1'b0, s[8].adc_p};
    n[9]      = s[8];
    n[9].v1d  = 64'h0000_8000_0000_0000 + 64'($signed(s[8].sqp3) >>> 8)
              + {s[8].v1p2[51:0], 12'b0};
    n[9].n0   = ({43'b0, pb} << 31) - s[8].v2;

    // Partial products with the unsigned coefficient and the scale constant.
    n[10]     = s[9];
    n[10].plo = s[9].v1d[31:0] * pcoef.p1;
    n[10].phi = s[9].v1d[63:32] * pcoef.p1;
    n[10].nlo = s[9].n0[31:0] * 12'(P_SCALE);
    n[10].nhi = s[9].n0[63:32] * 12'(P_SCALE);

    // Final divisor and dividend.
    n[11]     = s[10];
    n[11].v1e = 64'($signed(64'(s[10].plo) + {s[10].phi[31:0], 32'b0}) >>> 33);
    n[11].num = 64'(s[10].nlo) + {s[10].nhi[31:0], 32'b0};

    n[12] = s[11];
  end

  // Pipeline registers advance together whenever the queue has room.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        s[i] <= n[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], burst_valid};
    end
  end

  // Classify the divisor and split both operands into sign and magnitude.
  always_comb begin
    push_data.temp = s[12].temp;
    push_data.fine = s[12].fine;
    push_data.zero = (s[12].v1e == 64'b0);
    push_data.neg  = s[12].num[63] ^ s[12].v1e[63];
    push_data.mn   = s[12].num[63] ? -s[12].num : s[12].num;
    push_data.md   = s[12].v1e[63] ? -s[12].v1e : s[12].v1e;
  end

  assign push = en && v[NST-1];

endmodule

FILE: hw/rtl/bsc_back.sv
// ----------------------------------------------------------------------------
// bsc_back: pressure division and final correction
// A bit-per-stage restoring divider followed by six stages that apply the
// quadratic and linear corrections and hold the result for the consumer.
// ----------------------------------------------------------------------------
module bsc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                avail,
  input  bsc_pkg::qitem_t     pop_data,
  input  bsc_pkg::pcoef_t     pcoef,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  temperature_centi,
  output logic signed [31:0]  fine_temperature,
  output logic [31:0]         pressure_q24_8,
  output logic                divisor_zero
);

  import bsc_pkg::*;

  localparam int NPOST = 6;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        zero;
    logic        neg;
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] md;
  } ds_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        zero;
    logic [63:0] p;
    logic [63:0] ps;
    logic [63:0] ll;
    logic [31:0] lh;
    logic [47:0] p8lo;
    logic [47:0] p8hi;
    logic [63:0] sq2;
    logic [63:0] w2;
    logic [47:0] p9lo;
    logic [47:0] p9hi;
    logic [63:0] w1;
    logic [31:0] press;
  } es_t;

  logic en;
  ds_t  d [DIV_STEPS+1];
  ds_t  dn [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv;
  es_t  e [NPOST];
  es_t  en_n [NPOST];
  logic [NPOST-1:0] ev;
  logic [63:0] pp8;
  logic [63:0] pp9;
  logic [63:0] psum;

  // The whole back end moves when the output register is free or taken.
  assign en  = !ev[NPOST-1] || !result_stall;
  assign pop = en && avail;

  // Divider entry from the queue.
  always_comb begin
    dn[0].temp = pop_data.temp;
    dn[0].fine = pop_data.fine;
    dn[0].zero = pop_data.zero;
    dn[0].neg  = pop_data.neg;
    dn[0].rem  = 64'b0;
    dn[0].q    = pop_data.mn;
    dn[0].md   = pop_data.md;
  end

  // One quotient bit per stage: shift in a dividend bit, trial subtract.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    logic [64:0] trial;
    logic        fits;
    always_comb begin
      trial     = {d[i].rem, d[i].q[63]};
      fits      = (trial >= {1'b0, d[i].md});
      dn[i+1]   = d[i];
      dn[i+1].rem = fits ? 64'(trial - {1'b0, d[i].md}) : trial[63:0];
      dn[i+1].q   = {d[i].q[62:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= DIV_STEPS; i++) begin
        d[i] <= dn[i];
      end
    end
  end

  // Correction stages after the quotient.
  always_comb begin
    // Restore the sign of the quotient.
    en_n[0]      = e[0];
    en_n[0].temp = d[DIV_STEPS].temp;
    en_n[0].fine = d[DIV_STEPS].fine;
    en_n[0].zero = d[DIV_STEPS].zero;
    en_n[0].p    = d[DIV_STEPS].neg ? -d[DIV_STEPS].q : d[DIV_STEPS].q;
    en_n[0].ps   = 64'($signed(en_n[0].p) >>> 13);

    // Partials of the scaled square and of the linear term.
    en_n[1]      = e[0];
    en_n[1].ll   = {32'b0, e[0].ps[31:0]} * {32'b0, e[0].ps[31:0]};
    en_n[1].lh   = e[0].ps[31:0] * e[0].ps[63:32];
    en_n[1].p8lo = e[0].p[31:0] * pcoef.p8;
    en_n[1].p8hi = e[0].p[63:32] * pcoef.p8;

    // Square and linear correction.
    pp8          = 64'(e[1].p8lo) + {e[1].p8hi[31:0], 32'b0}
                 - (pcoef.p8[15] ? {e[1].p[47:0], 16'b0} : 64'b0);
    en_n[2]      = e[1];
    en_n[2].sq2  = e[1].ll + {e[1].lh[30:0], 33'b0};
    en_n[2].w2   = 64'($signed(pp8) >>> 19);

    // Partials of the square with the quadratic coefficient.
    en_n[3]      = e[2];
    en_n[3].p9lo = e[2].sq2[31:0] * pcoef.p9;
    en_n[3].p9hi = e[2].sq2[63:32] * pcoef.p9;

    // Quadratic correction.
    pp9          = 64'(e[3].p9lo) + {e[3].p9hi[31:0], 32'b0}
                 - (pcoef.p9[15] ? {e[3].sq2[47:0], 16'b0} : 64'b0);
    en_n[4]      = e[3];
    en_n[4].w1   = 64'($signed(pp9) >>> 25);

    // Final sum, scale and offset; zero divisor forces pressure to zero.
    psum          = 64'($signed(e[4].p + e[4].w1 + e[4].w2) >>> 8)
                  + ({{48{pcoef.p7[15]}}, pcoef.p7} << 4);
    en_n[5]       = e[4];
    en_n[5].press = e[4].zero ? 32'b0 : psum[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPOST; i++) begin
        e[i] <= en_n[i];
      end
    end
  end

  // Valid chain through divider and correction stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      ev <= '0;
    end else if (en) begin
      dv <= {dv[DIV_STEPS-1:0], avail};
      ev <= {ev[NPOST-2:0], dv[DIV_STEPS]};
    end
  end

  assign result_valid      = ev[NPOST-1];
  assign temperature_centi = $signed(e[NPOST-1].temp);
  assign fine_temperature  = $signed(e[NPOST-1].fine);
  assign pressure_q24_8    = e[NPOST-1].press;
  assign divisor_zero      = e[NPOST-1].zero;

endmodule

FILE: hw/rtl/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: integer temperature and pressure compensation
// Front pipeline, queue and divider back end for one raw six-byte burst.
// ----------------------------------------------------------------------------
// One burst is accepted per clock and one result leaves per clock while the
// consumer keeps up. A burst passes from acceptance to its result beat through
// 13 front stages (temperature, fine temperature and the dividend and divisor
// of the pressure formula), the queue, 65 stages of the bit-per-stage pressure
// divider (an entry register and 64 quotient steps), and 6 correction stages
// ending in the output register. A stall on the result side holds the back
// end; the queue absorbs QUEUE_DEPTH beats before the burst side is stalled.
// The user must write calibration registers only while no burst is in flight;
// the block itself does not enforce it.
module barometric_sensor_compensation #(
  parameter int QUEUE_DEPTH = bsc_pkg::BSC_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               burst_valid,
  output logic               burst_stall,
  input  logic [47:0]        raw_burst,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] temperature_centi,
  output logic signed [31:0] fine_temperature,
  output logic [31:0]        pressure_q24_8,
  output logic               divisor_zero
);

  import bsc_pkg::*;

  logic [47:0] temperature_coeffs;
  logic [63:0] pressure_coeffs_a;
  logic [63:0] pressure_coeffs_b;
  logic [15:0] pressure_coeff_nine;

  tcoef_t tcoef;
  pcoef_t pcoef;
  qitem_t push_data;
  qitem_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  logic   front_en;

  // Calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_coeffs  <= '0;
      pressure_coeffs_a   <= '0;
      pressure_coeffs_b   <= '0;
      pressure_coeff_nine <= '0;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP: temperature_coeffs  <= cfg_data[47:0];
        REG_PA:   pressure_coeffs_a   <= cfg_data;
        REG_PB:   pressure_coeffs_b   <= cfg_data;
        REG_P9:   pressure_coeff_nine <= cfg_data[15:0];
        default:  ;
      endcase
    end
  end

  assign tcoef = tcoef_t'(temperature_coeffs);
  assign pcoef = pcoef_t'({pressure_coeff_nine, pressure_coeffs_b, pressure_coeffs_a});

  // The front advances while the queue has room.
  assign front_en    = !full;
  assign burst_stall = !front_en;

  bsc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (front_en),
    .burst_valid (burst_valid),
    .raw_burst   (raw_burst),
    .tcoef       (tcoef),
    .pcoef       (pcoef),
    .push        (push),
    .push_data   (push_data)
  );

  bsc_fifo #(
    .WIDTH ($bits(qitem_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  bsc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .avail             (!empty),
    .pop_data          (pop_data),
    .pcoef             (pcoef),
    .pop               (pop),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .temperature_centi (temperature_centi),
    .fine_temperature  (fine_temperature),
    .pressure_q24_8    (pressure_q24_8),
    .divisor_zero      (divisor_zero)
  );

endmodule
